FILE: design/mmt_pkg.sv
// Package for the matrix multiply transpose unit.
// Holds sizes, request and register codes, payload and control structs, and helpers.
// No dependencies.
package mmt_pkg;

    localparam int MAX_DIM     = 64;
    localparam int STORE_DEPTH = 4096;
    localparam int DATA_WIDTH  = 16;

    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
    localparam int STORE_AW  = $clog2(STORE_DEPTH);
    localparam int PROD_W    = 2 * DATA_WIDTH;
    localparam int ACC_W     = 48;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int REQ_W     = 2;
    localparam int IDX_W     = 12;
    localparam int VAL_W     = 16;
    localparam int POS_W     = 6;

    localparam logic [REQ_W-1:0] REQ_LOAD_LHS = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_RHS = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_M          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_N          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_K          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LHS_TRANSPOSED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RHS_TRANSPOSED = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [IDX_W-1:0]        elem_index;
        logic signed [VAL_W-1:0] elem_value;
        logic [POS_W-1:0]        out_row;
        logic [POS_W-1:0]        out_col;
    } mmt_req_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] out_value;
        logic [POS_W-1:0]        res_row;
        logic [POS_W-1:0]        res_col;
        logic                    range_error;
    } mmt_res_t;

    typedef struct packed {
        logic accept;
        logic capture;
        logic setup;
        logic issue;
        logic finish;
    } mmt_cmd_t;

    typedef struct packed {
        logic last_step;
        logic range_err;
        logic busy;
        logic out_full;
    } mmt_status_t;

    // Dimension registers saturate to the range one to MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        else if (32'(v) > MAX_DIM)
            return DIM_W'(MAX_DIM);
        else
            return DIM_W'(v);
    endfunction

endpackage

FILE: design/mmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mmt_ctrl.sv
// Controller state machine of the matrix multiply transpose unit.
// Depends on mmt_pkg for the command and status structs and request codes.
module mmt_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic [mmt_pkg::REQ_W-1:0] req_type,
    output logic                      req_ready,
    input  logic                      res_ready,
    input  mmt_pkg::mmt_status_t      status,
    output mmt_pkg::mmt_cmd_t         cmd
);

    import mmt_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN, ST_DRAIN} state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = req_valid && ready_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && req_type == REQ_COMPUTE)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.range_err ? ST_DRAIN : ST_RUN;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy && (!status.out_full || res_ready))
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign req_ready = ready_reg;

    a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && req_type == REQ_COMPUTE) |=> state_reg == ST_SETUP)
        else $error("compute transfer did not start the setup step");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> state_reg == ST_IDLE)
        else $error("request ready outside the idle state");

endmodule

FILE: design/mmt_datapath.sv
// Datapath of the matrix multiply transpose unit: registers, operand stores,
// address stepping, multiply-accumulate pipeline and output register.
// Depends on mmt_pkg and mmt_ram.
module mmt_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mmt_pkg::CFG_W-1:0]     cfg_data,
    input  mmt_pkg::mmt_req_t             req_data,
    input  mmt_pkg::mmt_cmd_t             cmd,
    output mmt_pkg::mmt_status_t          status,
    output logic                          res_valid,
    input  logic                          res_ready,
    output mmt_pkg::mmt_res_t             res_data
);

    import mmt_pkg::*;

    logic [DIM_W-1:0] dim_m_reg;
    logic [DIM_W-1:0] dim_n_reg;
    logic [DIM_W-1:0] dim_k_reg;
    logic             lhs_t_reg;
    logic             rhs_t_reg;

    logic [POS_W-1:0]  row_reg;
    logic [POS_W-1:0]  col_reg;
    logic              range_err_reg;
    logic [ADDR_W-1:0] lhs_addr_reg;
    logic [ADDR_W-1:0] rhs_addr_reg;
    logic [DIM_W-1:0]  lhs_stride_reg;
    logic [DIM_W-1:0]  rhs_stride_reg;
    logic [DIM_W-1:0]  count_reg;

    logic                     v1_reg;
    logic                     v2_reg;
    logic                     lhs_oob_reg;
    logic                     rhs_oob_reg;
    logic signed [PROD_W-1:0] product_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic     res_valid_reg;
    logic     res_valid_next;
    mmt_res_t res_data_reg;

    logic                         load_ok;
    logic                         lhs_we;
    logic                         rhs_we;
    logic signed [31:0]           value_ext;
    logic [DATA_WIDTH-1:0]        lhs_rdata;
    logic [DATA_WIDTH-1:0]        rhs_rdata;
    logic signed [DATA_WIDTH-1:0] lhs_op;
    logic signed [DATA_WIDTH-1:0] rhs_op;

    assign load_ok   = cmd.accept && (32'(req_data.elem_index) < STORE_DEPTH);
    assign lhs_we    = load_ok && req_data.req_type == REQ_LOAD_LHS;
    assign rhs_we    = load_ok && req_data.req_type == REQ_LOAD_RHS;
    assign value_ext = 32'(req_data.elem_value);

    mmt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_DEPTH)) u_lhs_ram (
        .clk   (clk),
        .we    (lhs_we),
        .waddr (STORE_AW'(req_data.elem_index)),
        .wdata (value_ext[DATA_WIDTH-1:0]),
        .raddr (STORE_AW'(lhs_addr_reg)),
        .rdata (lhs_rdata)
    );

    mmt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_DEPTH)) u_rhs_ram (
        .clk   (clk),
        .we    (rhs_we),
        .waddr (STORE_AW'(req_data.elem_index)),
        .wdata (value_ext[DATA_WIDTH-1:0]),
        .raddr (STORE_AW'(rhs_addr_reg)),
        .rdata (rhs_rdata)
    );

    // Reads beyond the store return zero.
    assign lhs_op = lhs_oob_reg ? '0 : $signed(lhs_rdata);
    assign rhs_op = rhs_oob_reg ? '0 : $signed(rhs_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_m_reg <= DIM_W'(MAX_DIM);
            dim_n_reg <= DIM_W'(MAX_DIM);
            dim_k_reg <= DIM_W'(MAX_DIM);
            lhs_t_reg <= 1'b0;
            rhs_t_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DIM_M:          dim_m_reg <= clamp_dim(cfg_data);
                CFG_DIM_N:          dim_n_reg <= clamp_dim(cfg_data);
                CFG_DIM_K:          dim_k_reg <= clamp_dim(cfg_data);
                CFG_LHS_TRANSPOSED: lhs_t_reg <= cfg_data[0];
                CFG_RHS_TRANSPOSED: rhs_t_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg       <= req_data.out_row;
            col_reg       <= req_data.out_col;
            range_err_reg <= (32'(req_data.out_row) >= 32'(dim_m_reg))
                          || (32'(req_data.out_col) >= 32'(dim_n_reg));
        end
        if (cmd.setup)
        begin
            lhs_addr_reg   <= lhs_t_reg ? ADDR_W'(row_reg) * ADDR_W'(dim_k_reg)
                                        : ADDR_W'(row_reg);
            lhs_stride_reg <= lhs_t_reg ? DIM_W'(1) : dim_m_reg;
            rhs_addr_reg   <= rhs_t_reg ? ADDR_W'(col_reg)
                                        : ADDR_W'(col_reg) * ADDR_W'(dim_k_reg);
            rhs_stride_reg <= rhs_t_reg ? dim_n_reg : DIM_W'(1);
            count_reg      <= '0;
        end
        else if (cmd.issue)
        begin
            lhs_addr_reg <= lhs_addr_reg + ADDR_W'(lhs_stride_reg);
            rhs_addr_reg <= rhs_addr_reg + ADDR_W'(rhs_stride_reg);
            count_reg    <= count_reg + 1'b1;
        end
        lhs_oob_reg <= !(32'(lhs_addr_reg) < STORE_DEPTH);
        rhs_oob_reg <= !(32'(rhs_addr_reg) < STORE_DEPTH);
        product_reg <= lhs_op * rhs_op;
        if (cmd.setup)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(product_reg);
        end
        if (cmd.finish)
        begin
            res_data_reg.out_value   <= acc_reg;
            res_data_reg.res_row     <= row_reg;
            res_data_reg.res_col     <= col_reg;
            res_data_reg.range_error <= range_err_reg;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.finish)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            res_valid_reg <= res_valid_next;
        end
    end

    assign status.last_step = (count_reg == dim_k_reg - 1'b1);
    assign status.range_err = range_err_reg;
    assign status.busy      = v1_reg || v2_reg;
    assign status.out_full  = res_valid_reg;

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!res_valid_reg || res_ready))
        else $error("result register overwritten before its transfer");

    a_no_issue_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !range_err_reg)
        else $error("store read issued for an out-of-range element");

    a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (lhs_we || rhs_we) |-> (!v1_reg && !v2_reg && !cmd.issue))
        else $error("store write while the multiply pipeline is active");

endmodule

FILE: design/matrix_multiply_transpose_unit.sv
// Matrix multiply transpose unit: one element of a matrix product per compute transfer.
// Load transfers are accepted back to back while the unit is idle. A compute transfer
// performs one multiply-accumulate per cycle over the inner dimension, and no new
// transfer is accepted until it finishes; an out-of-range element skips those steps.
// Reset is asynchronous, active low; dimensions reset to 64, both transpose bits to 0,
// and the operand stores are not cleared.
module matrix_multiply_transpose_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mmt_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  mmt_pkg::mmt_req_t             req_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output mmt_pkg::mmt_res_t             res_data
);

    import mmt_pkg::*;

    mmt_cmd_t    cmd;
    mmt_status_t status;

    mmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_data.req_type),
        .req_ready (req_ready),
        .res_ready (res_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mmt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

FILE: sim/matrix_multiply_transpose_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for matrix_multiply_transpose_unit: directed and random load and compute traffic.
// A scoreboard class predicts each output element; depends on mmt_pkg and the unit itself.
module matrix_multiply_transpose_unit_tb;
    import mmt_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 500;

    class element_scoreboard;
        logic signed [DATA_WIDTH-1:0] lhs_mem [STORE_DEPTH];
        logic signed [DATA_WIDTH-1:0] rhs_mem [STORE_DEPTH];
        bit lhs_written [STORE_DEPTH];
        bit rhs_written [STORE_DEPTH];
        int rows;
        int cols;
        int depth;
        bit lhs_t;
        bit rhs_t;
        mmt_res_t awaited_elements [$];
        int errors;

        function new();
            rows = MAX_DIM;
            cols = MAX_DIM;
            depth = MAX_DIM;
            lhs_t = 1'b0;
            rhs_t = 1'b0;
            errors = 0;
        endfunction

        function int saturate_dim(logic [CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (int'(v) > MAX_DIM)
                return MAX_DIM;
            return int'(v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_DIM_M: rows = saturate_dim(v);
                CFG_DIM_N: cols = saturate_dim(v);
                CFG_DIM_K: depth = saturate_dim(v);
                CFG_LHS_TRANSPOSED: lhs_t = v[0];
                CFG_RHS_TRANSPOSED: rhs_t = v[0];
                default: ;
            endcase
        endfunction

        function int lhs_addr(int i, int l);
            return lhs_t ? i * depth + l : l * rows + i;
        endfunction

        function int rhs_addr(int j, int l);
            return rhs_t ? l * cols + j : j * depth + l;
        endfunction

        function void note_request(mmt_req_t r);
            mmt_res_t e;
            longint acc;
            longint a;
            longint b;
            int la;
            int ra;
            int l;
            if (r.req_type == REQ_LOAD_LHS)
            begin
                lhs_mem[r.elem_index] = r.elem_value;
                lhs_written[r.elem_index] = 1'b1;
            end
            else if (r.req_type == REQ_LOAD_RHS)
            begin
                rhs_mem[r.elem_index] = r.elem_value;
                rhs_written[r.elem_index] = 1'b1;
            end
            else if (r.req_type == REQ_COMPUTE)
            begin
                e.res_row = r.out_row;
                e.res_col = r.out_col;
                if (int'(r.out_row) >= rows || int'(r.out_col) >= cols)
                begin
                    e.out_value = '0;
                    e.range_error = 1'b1;
                end
                else
                begin
                    acc = 0;
                    for (l = 0; l < depth; l++)
                    begin
                        la = lhs_addr(r.out_row, l);
                        ra = rhs_addr(r.out_col, l);
                        a = (la < STORE_DEPTH) ? longint'(lhs_mem[la]) : 0;
                        b = (ra < STORE_DEPTH) ? longint'(rhs_mem[ra]) : 0;
                        acc += a * b;
                    end
                    e.out_value = acc[ACC_W-1:0];
                    e.range_error = 1'b0;
                end
                awaited_elements.push_back(e);
            end
        endfunction

        function void check_result(mmt_res_t got);
            mmt_res_t e;
            if (awaited_elements.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: value %0d row %0d col %0d range_error %0b",
                             got.out_value, got.res_row, got.res_col, got.range_error);
                return;
            end
            e = awaited_elements.pop_front();
            if (got.out_value !== e.out_value || got.res_row !== e.res_row ||
                got.res_col !== e.res_col || got.range_error !== e.range_error)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: expected value %0d row %0d col %0d err %0b,",
                             e.out_value, e.res_row, e.res_col, e.range_error);
                    $display("          got value %0d row %0d col %0d err %0b",
                             got.out_value, got.res_row, got.res_col, got.range_error);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic req_valid;
    logic req_ready;
    mmt_req_t req_data;
    logic res_valid;
    logic res_ready;
    mmt_res_t res_data;

    element_scoreboard products = new();
    bit no_idle = 1'b0;
    bit hold_pending = 1'b0;
    int items_sent = 0;
    int idle_cycles;

    matrix_multiply_transpose_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data(res_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((req_valid && req_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("matrix_multiply_transpose_unit verification failed");
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = no_idle ? 0 : $urandom_range(0, 7);
                if (gap > 0)
                begin
                    res_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            products.check_result(res_data);
        end
    end

    function automatic mmt_req_t random_request();
        mmt_req_t r;
        r.req_type = 2'($urandom_range(0, 3));
        r.elem_index = 12'($urandom);
        r.elem_value = 16'($urandom);
        r.out_row = 6'($urandom);
        r.out_col = 6'($urandom);
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] flag_data(bit f);
        return {6'($urandom_range(0, 63)), f};
    endfunction

    task automatic send_item(input mmt_req_t item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        products.note_request(item);
    endtask

    task automatic load_elem(input logic [REQ_W-1:0] kind, input int idx,
                             input logic [VAL_W-1:0] v);
        mmt_req_t r;
        r = random_request();
        r.req_type = kind;
        r.elem_index = idx[IDX_W-1:0];
        r.elem_value = v;
        send_item(r);
        items_sent++;
    endtask

    // Operands of an in-range element are loaded first wherever they were never written.
    task automatic request_element(input int i, input int j);
        mmt_req_t r;
        int l;
        int a;
        if (i < products.rows && j < products.cols)
        begin
            for (l = 0; l < products.depth; l++)
            begin
                a = products.lhs_addr(i, l);
                if (!products.lhs_written[a])
                    load_elem(REQ_LOAD_LHS, a, random_value());
                a = products.rhs_addr(j, l);
                if (!products.rhs_written[a])
                    load_elem(REQ_LOAD_RHS, a, random_value());
            end
        end
        r = random_request();
        r.req_type = REQ_COMPUTE;
        r.out_row = i[POS_W-1:0];
        r.out_col = j[POS_W-1:0];
        send_item(r);
        items_sent++;
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (products.awaited_elements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        products.write_reg(idx, v);
    endtask

    task automatic configure(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] n,
                             input logic [CFG_W-1:0] k, input logic [CFG_W-1:0] lt,
                             input logic [CFG_W-1:0] rt);
        settle();
        write_reg(CFG_DIM_M, m);
        write_reg(CFG_DIM_N, n);
        write_reg(CFG_DIM_K, k);
        write_reg(CFG_LHS_TRANSPOSED, lt);
        write_reg(CFG_RHS_TRANSPOSED, rt);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input int count, input bit press);
        int base;
        int pick;
        mmt_req_t r;
        base = items_sent;
        if (press)
        begin
            hold_pending = 1'b1;
            no_idle = 1'b1;
        end
        while (items_sent - base < count)
        begin
            if (press && items_sent - base >= 60)
                no_idle = 1'b0;
            else if (!press && (items_sent - base) % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                request_element($urandom_range(0, products.rows - 1),
                                $urandom_range(0, products.cols - 1));
            else if (pick < 55)
                request_element($urandom_range(0, 63), $urandom_range(0, 63));
            else if (pick < 70)
                load_elem(REQ_LOAD_LHS,
                          $urandom_range(0, products.rows * products.depth - 1),
                          random_value());
            else if (pick < 85)
                load_elem(REQ_LOAD_RHS,
                          $urandom_range(0, products.cols * products.depth - 1),
                          random_value());
            else if (pick < 97)
                load_elem($urandom_range(0, 1) ? REQ_LOAD_RHS : REQ_LOAD_LHS,
                          $urandom_range(0, STORE_DEPTH - 1), random_value());
            else
            begin
                r = random_request();
                r.req_type = REQ_UNUSED;
                send_item(r);
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        mmt_req_t r;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        req_valid <= 1'b0;
        req_data <= '0;
        res_ready <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(7'd127, 7'd0, 7'd2, {6'h3f, 1'b0}, {6'h00, 1'b1});
        load_elem(REQ_LOAD_LHS, 0, 16'h8000);
        load_elem(REQ_LOAD_LHS, 64, 16'h7fff);
        load_elem(REQ_LOAD_RHS, 0, 16'h8000);
        load_elem(REQ_LOAD_RHS, 1, 16'h8000);
        request_element(0, 0);
        load_elem(REQ_LOAD_LHS, 63, 16'h7fff);
        load_elem(REQ_LOAD_LHS, 127, 16'h7fff);
        request_element(63, 0);
        request_element(63, 63);
        request_element(0, 1);
        r = '1;
        r.req_type = REQ_UNUSED;
        send_item(r);
        load_elem(REQ_LOAD_LHS, 4095, 16'hffff);
        load_elem(REQ_LOAD_RHS, 4095, 16'h0000);
        load_elem(REQ_LOAD_RHS, 12'haaa, 16'haaaa);
        load_elem(REQ_LOAD_LHS, 12'h555, 16'h5555);
        load_elem(REQ_LOAD_LHS, 63, 16'hffff);
        request_element(63, 0);

        configure(7'd64, 7'd64, 7'd64, flag_data(1'b0), flag_data(1'b0));
        random_phase(120, 1'b0);
        configure(7'd4, 7'd5, 7'd3, flag_data(1'b1), flag_data(1'b0));
        random_phase(200, 1'b0);
        configure(7'd1, 7'd1, 7'd1, flag_data(1'b0), flag_data(1'b1));
        random_phase(60, 1'b0);
        configure(7'd8, 7'd8, 7'd8, flag_data(1'b1), flag_data(1'b1));
        random_phase(200, 1'b1);
        configure(7'd64, 7'd1, 7'd5, flag_data(1'b0), flag_data(1'b1));
        random_phase(150, 1'b0);
        configure(7'd1, 7'd64, 7'd7, flag_data(1'b1), flag_data(1'b0));
        random_phase(150, 1'b0);
        configure(7'd3, 7'd7, 7'd64, flag_data(1'b1), flag_data(1'b1));
        random_phase(120, 1'b0);
        configure(7'($urandom_range(0, 20)), 7'($urandom_range(0, 20)),
                  7'($urandom_range(0, 20)), flag_data(1'($urandom_range(0, 1))),
                  flag_data(1'($urandom_range(0, 1))));
        random_phase(200, 1'b0);

        settle();
        if (products.errors == 0 && products.awaited_elements.size() == 0)
            $display("matrix_multiply_transpose_unit verification clean");
        else
            $display("matrix_multiply_transpose_unit verification failed");
        $finish;
    end

endmodule
